// ----- src/ist_pkg.sv -----
// Package for the identifier set table: field widths, operation and status codes,
// the sequencer state type and the control word that steers the entry cells.
// No dependencies.
package ist_pkg;

    localparam int OP_W     = 3;
    localparam int KEY_W    = 64;
    localparam int IDX_W    = 6;
    localparam int POS_W    = 6;
    localparam int ECOUNT_W = 7;
    localparam int STAT_W   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 3'd0,
        OP_REMOVE = 3'd1,
        OP_LOOKUP = 3'd2,
        OP_READ   = 3'd3,
        OP_CLEAR  = 3'd4
    } t_opcode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_CMP  = 2'd1,
        S_EXEC = 2'd2
    } t_state;

    typedef struct packed {
        logic cmp;
        logic append;
        logic shift;
    } t_cell_ctl;

endpackage

// ----- src/ist_if.sv -----
// Valid/ready channel interfaces for the identifier set table.
// Depends on ist_pkg for the field widths.
interface ist_in_if;
    logic                        valid;
    logic                        ready;
    logic [ist_pkg::OP_W-1:0]    opcode;
    logic [ist_pkg::KEY_W-1:0]   key_high;
    logic [ist_pkg::KEY_W-1:0]   key_low;
    logic [ist_pkg::IDX_W-1:0]   entry_index;

    modport source (output valid, opcode, key_high, key_low, entry_index, input ready);
    modport sink   (input valid, opcode, key_high, key_low, entry_index, output ready);
endinterface

interface ist_out_if;
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic [ist_pkg::POS_W-1:0]    position;
    logic [ist_pkg::KEY_W-1:0]    out_key_high;
    logic [ist_pkg::KEY_W-1:0]    out_key_low;
    logic [ist_pkg::ECOUNT_W-1:0] entry_count;
    logic [ist_pkg::STAT_W-1:0]   status;

    modport source (output valid, found, position, out_key_high, out_key_low, entry_count,
                    status, input ready);
    modport sink   (input valid, found, position, out_key_high, out_key_low, entry_count,
                    status, output ready);
endinterface

// ----- src/ist_cell.sv -----
// One entry cell of the set table: holds one identifier, compares it with the
// broadcast key, and takes its right neighbor's identifier when an entry is removed.
// Depends on ist_pkg.
module ist_cell #(
    parameter int CNT_W = 7,
    parameter int SEL_W = 7,
    parameter int IX    = 0
) (
    input  logic                      i_clk,
    input  ist_pkg::t_cell_ctl        i_ctl,
    input  logic [CNT_W-1:0]          i_count,
    input  logic [SEL_W-1:0]          i_sel_idx,
    input  logic [ist_pkg::KEY_W-1:0] i_key_high,
    input  logic [ist_pkg::KEY_W-1:0] i_key_low,
    input  logic [ist_pkg::KEY_W-1:0] i_nbr_high,
    input  logic [ist_pkg::KEY_W-1:0] i_nbr_low,
    input  logic                      i_hit,
    output logic [ist_pkg::KEY_W-1:0] o_key_high,
    output logic [ist_pkg::KEY_W-1:0] o_key_low,
    output logic                      o_hit,
    output logic                      o_first,
    output logic                      o_rd_sel
);

    logic [ist_pkg::KEY_W-1:0] r_key_high;
    logic [ist_pkg::KEY_W-1:0] r_key_low;
    logic                      r_match;
    logic                      r_rd_sel;
    logic                      valid;
    logic                      is_tail;

    assign valid   = CNT_W'(IX) < i_count;
    assign is_tail = CNT_W'(IX) == i_count;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_match  <= valid && (r_key_high == i_key_high) && (r_key_low == i_key_low);
            r_rd_sel <= valid && (SEL_W'(IX) == i_sel_idx);
        end
        if (i_ctl.append && is_tail) begin
            r_key_high <= i_key_high;
            r_key_low  <= i_key_low;
        end else if (i_ctl.shift && (i_hit || r_match)) begin
            r_key_high <= i_nbr_high;
            r_key_low  <= i_nbr_low;
        end
    end

    assign o_key_high = r_key_high;
    assign o_key_low  = r_key_low;
    assign o_hit      = i_hit | r_match;
    assign o_first    = r_match & ~i_hit;
    assign o_rd_sel   = r_rd_sel;

endmodule

// ----- src/id_set_table_core.sv -----
// Identifier set table: a row of entry cells holding an ordered set of 128-bit keys.
// Each operation passes through three steps: capture, parallel compare in every cell, execute.
// A new transfer is accepted only when idle; execute waits while the result register is full.
// The result register lets the next transfer enter while a result still waits.
// Synchronous active-low reset empties the set; cell contents are not cleared.
// Depends on ist_pkg, ist_if and ist_cell.
module id_set_table_core #(
    parameter int CAPACITY = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ist_in_if.sink    i_in,
    ist_out_if.source o_out
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CIX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int SEL_W = (CNT_W > ist_pkg::IDX_W) ? CNT_W : ist_pkg::IDX_W;
    localparam int PW    = (CIX_W > ist_pkg::POS_W) ? CIX_W : ist_pkg::POS_W;
    localparam int CW    = (CNT_W > ist_pkg::ECOUNT_W) ? CNT_W : ist_pkg::ECOUNT_W;

    ist_pkg::t_state              r_state, n_state;
    logic [ist_pkg::OP_W-1:0]     r_op;
    logic [ist_pkg::KEY_W-1:0]    r_key_high;
    logic [ist_pkg::KEY_W-1:0]    r_key_low;
    logic [ist_pkg::IDX_W-1:0]    r_idx;
    logic [CNT_W-1:0]             r_count, n_count;

    logic                         r_out_valid;
    logic                         r_found;
    logic [ist_pkg::POS_W-1:0]    r_pos;
    logic [ist_pkg::KEY_W-1:0]    r_okh;
    logic [ist_pkg::KEY_W-1:0]    r_okl;
    logic [ist_pkg::ECOUNT_W-1:0] r_cnt_out;
    ist_pkg::t_status             r_status;

    ist_pkg::t_cell_ctl           ctl;
    logic                         accept;
    logic                         out_free;
    logic                         do_exec;
    logic                         res_found;
    logic [ist_pkg::POS_W-1:0]    res_pos;
    logic [ist_pkg::KEY_W-1:0]    res_okh;
    logic [ist_pkg::KEY_W-1:0]    res_okl;
    ist_pkg::t_status             res_status;
    logic [CW-1:0]                cnt_wide;

    logic [ist_pkg::KEY_W-1:0]    cell_high [CAPACITY];
    logic [ist_pkg::KEY_W-1:0]    cell_low  [CAPACITY];
    logic [CAPACITY:0]            hit_chain;
    logic [CAPACITY-1:0]          first;
    logic [CAPACITY-1:0]          rd_sel;
    logic [PW-1:0]                pos_wide;
    logic [ist_pkg::KEY_W-1:0]    rd_high;
    logic [ist_pkg::KEY_W-1:0]    rd_low;
    logic                         any_rd;

    assign hit_chain[0] = 1'b0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [ist_pkg::KEY_W-1:0] nbr_high;
        logic [ist_pkg::KEY_W-1:0] nbr_low;
        if (g == CAPACITY - 1) begin : g_last
            assign nbr_high = cell_high[g];
            assign nbr_low  = cell_low[g];
        end else begin : g_mid
            assign nbr_high = cell_high[g+1];
            assign nbr_low  = cell_low[g+1];
        end
        ist_cell #(
            .CNT_W (CNT_W),
            .SEL_W (SEL_W),
            .IX    (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (ctl),
            .i_count    (r_count),
            .i_sel_idx  (SEL_W'(r_idx)),
            .i_key_high (r_key_high),
            .i_key_low  (r_key_low),
            .i_nbr_high (nbr_high),
            .i_nbr_low  (nbr_low),
            .i_hit      (hit_chain[g]),
            .o_key_high (cell_high[g]),
            .o_key_low  (cell_low[g]),
            .o_hit      (hit_chain[g+1]),
            .o_first    (first[g]),
            .o_rd_sel   (rd_sel[g])
        );
    end

    always_comb begin
        pos_wide = '0;
        rd_high  = '0;
        rd_low   = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (first[i]) begin
                pos_wide = pos_wide | PW'(i);
            end
            if (rd_sel[i]) begin
                rd_high = rd_high | cell_high[i];
                rd_low  = rd_low | cell_low[i];
            end
        end
    end

    assign any_rd   = |rd_sel;
    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign do_exec  = (r_state == ist_pkg::S_EXEC) && out_free;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        ctl        = '0;
        res_found  = 1'b0;
        res_pos    = '0;
        res_okh    = '0;
        res_okl    = '0;
        res_status = ist_pkg::ST_OK;
        unique case (r_state)
            ist_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = ist_pkg::S_CMP;
                end
            end
            ist_pkg::S_CMP: begin
                ctl.cmp = 1'b1;
                n_state = ist_pkg::S_EXEC;
            end
            ist_pkg::S_EXEC: begin
                unique case (r_op)
                    ist_pkg::OP_ADD: begin
                        if (hit_chain[CAPACITY]) begin
                            res_found = 1'b1;
                            res_pos   = pos_wide[ist_pkg::POS_W-1:0];
                        end else if (r_count == CNT_W'(CAPACITY)) begin
                            res_status = ist_pkg::ST_FULL;
                        end else begin
                            ctl.append = do_exec;
                            n_count    = r_count + CNT_W'(1);
                        end
                    end
                    ist_pkg::OP_REMOVE: begin
                        if (hit_chain[CAPACITY]) begin
                            res_found = 1'b1;
                            res_pos   = pos_wide[ist_pkg::POS_W-1:0];
                            ctl.shift = do_exec;
                            n_count   = r_count - CNT_W'(1);
                        end
                    end
                    ist_pkg::OP_LOOKUP: begin
                        res_found = hit_chain[CAPACITY];
                        res_pos   = pos_wide[ist_pkg::POS_W-1:0];
                    end
                    ist_pkg::OP_READ: begin
                        if (any_rd) begin
                            res_okh = rd_high;
                            res_okl = rd_low;
                        end else begin
                            res_status = ist_pkg::ST_RANGE;
                        end
                    end
                    ist_pkg::OP_CLEAR: begin
                        n_count = '0;
                    end
                    default: begin
                    end
                endcase
                if (do_exec) begin
                    n_state = ist_pkg::S_IDLE;
                end else begin
                    n_count = r_count;
                end
            end
            default: begin
                n_state = ist_pkg::S_IDLE;
            end
        endcase
    end

    assign cnt_wide = CW'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ist_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (do_exec) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op       <= i_in.opcode;
            r_key_high <= i_in.key_high;
            r_key_low  <= i_in.key_low;
            r_idx      <= i_in.entry_index;
        end
        if (do_exec) begin
            r_found   <= res_found;
            r_pos     <= res_pos;
            r_okh     <= res_okh;
            r_okl     <= res_okl;
            r_cnt_out <= cnt_wide[ist_pkg::ECOUNT_W-1:0];
            r_status  <= res_status;
        end
    end

    assign i_in.ready         = (r_state == ist_pkg::S_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.found        = r_found;
    assign o_out.position     = r_pos;
    assign o_out.out_key_high = r_okh;
    assign o_out.out_key_low  = r_okl;
    assign o_out.entry_count  = r_cnt_out;
    assign o_out.status       = r_status;

endmodule

// ----- src/ist_checker.sv -----
// Port-level checks for the identifier set table and the bind that attaches them.
// Depends on ist_pkg and id_set_table_core.
module ist_checker #(
    parameter int CAPACITY = 64
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_found,
    input logic [ist_pkg::POS_W-1:0]    i_position,
    input logic [ist_pkg::KEY_W-1:0]    i_okh,
    input logic [ist_pkg::KEY_W-1:0]    i_okl,
    input logic [ist_pkg::ECOUNT_W-1:0] i_count,
    input logic [ist_pkg::STAT_W-1:0]   i_status
);

    localparam logic [ist_pkg::ECOUNT_W-1:0] FULL_COUNT =
        ist_pkg::ECOUNT_W'(CAPACITY % (1 << ist_pkg::ECOUNT_W));

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ist_pkg::ST_FULL) |-> i_count == FULL_COUNT)
        else $error("full status reported with a count below capacity");

    a_range_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ist_pkg::ST_RANGE) |->
            !i_found && (i_okh == '0) && (i_okl == '0))
        else $error("range error carries data");

    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_found |-> i_position == '0)
        else $error("position set without a match");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second transfer taken while an operation is in flight");

endmodule

bind id_set_table_core ist_checker #(.CAPACITY(CAPACITY)) u_ist_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_found     (o_out.found),
    .i_position  (o_out.position),
    .i_okh       (o_out.out_key_high),
    .i_okl       (o_out.out_key_low),
    .i_count     (o_out.entry_count),
    .i_status    (o_out.status)
);
